// ----- sv/drld_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Data run list decoder package
// Types, fixed constants and a byte merge function shared by the run list decoder.
// ----------------------------------------------------------------------------
package drld_pkg;

  localparam int unsigned ByteW      = 8;
  localparam int unsigned ClusterW   = 64;
  localparam int unsigned FieldBytes = ClusterW / ByteW;
  localparam int unsigned IdxW       = $clog2(FieldBytes);
  localparam int unsigned SizeW      = 4;

  // Largest field size that a header nibble may give.
  localparam logic [SizeW-1:0] MaxFieldBytes = SizeW'(FieldBytes);
  localparam logic [ByteW-1:0] EndHeader     = 8'h00;

  // Decoder phases
  localparam logic [1:0] PhHeader = 2'd0;
  localparam logic [1:0] PhLength = 2'd1;
  localparam logic [1:0] PhOffset = 2'd2;
  localparam logic [1:0] PhIgnore = 2'd3;

  typedef struct packed {
    logic [ClusterW-1:0] start_cluster;
    logic [ClusterW-1:0] cluster_count;
    logic                sparse;
    logic                bad;
    logic                list_end;
  } result_t;

  // Merge one byte into a little-endian accumulator at byte position idx.
  function automatic logic [ClusterW-1:0] put_byte(input logic [ClusterW-1:0] acc,
                                                   input logic [IdxW-1:0]     idx,
                                                   input logic [ByteW-1:0]    b);
    logic [ClusterW-1:0] res;
    res = acc;
    for (int k = 0; k < FieldBytes; k++) begin
      if (idx == IdxW'(k)) begin
        res[k*ByteW +: ByteW] = b;
      end
    end
    return res;
  endfunction

endpackage

// ----- sv/data_run_list_decoder.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Data run list decoder
// Decodes a mapping-pair run list byte by byte into absolute runs.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel carries one run list byte per transfer, with
//   list_start_i marking the first header byte of a new list; it clears the
//   running start cluster and drops any partly read run.
//   The output channel carries one result per finished run, per bad header
//   and per zero terminator. Header and field bytes that do not finish a run
//   give no result.
//   Throughput is one byte per cycle while not stalled. A result is presented
//   on the output register in the cycle after its completing byte is taken.
//   The single output register decouples the sides: input is stalled only
//   while a result is held and the receiver stalls, so the next byte is taken
//   in the same cycle a waiting result leaves.
//   Reset clears the decoder to wait for a header with a zero start cluster,
//   as if a list had begun, and empties the output register.
// ----------------------------------------------------------------------------
module data_run_list_decoder
  import drld_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [ByteW-1:0]    run_byte_i,
  input  logic                list_start_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [ClusterW-1:0] run_start_cluster_o,
  output logic [ClusterW-1:0] run_cluster_count_o,
  output logic                sparse_run_o,
  output logic                bad_run_o,
  output logic                list_end_o
);

  logic [1:0]          phase_q, phase_d;
  logic [SizeW-1:0]    bytes_left_q, bytes_left_d;
  logic [SizeW-1:0]    offset_size_q, offset_size_d;
  logic [IdxW-1:0]     byte_index_q, byte_index_d;
  logic [ClusterW-1:0] length_acc_q, length_acc_d;
  logic [ClusterW-1:0] offset_acc_q, offset_acc_d;
  logic [ClusterW-1:0] prev_cluster_q, prev_cluster_d;
  logic                out_valid_q, out_valid_d;
  result_t             result_q, result_d;

  logic                in_xfer;
  logic                out_xfer;
  logic                res_new;
  logic [1:0]          phase_eff;
  logic [ClusterW-1:0] prev_eff;
  logic [SizeW-1:0]    lo_nib, hi_nib;
  logic                last_byte;
  logic [ClusterW-1:0] length_merged;
  logic [ClusterW-1:0] offset_ext;
  logic [ClusterW:0]   sum_wide;
  logic                off_neg;

  assign in_stall_o = out_valid_q & out_stall_i;
  assign in_xfer    = in_valid_i & ~in_stall_o;
  assign out_xfer   = out_valid_q & ~out_stall_i;

  assign phase_eff = list_start_i ? PhHeader : phase_q;
  assign prev_eff  = list_start_i ? '0 : prev_cluster_q;
  assign lo_nib    = run_byte_i[SizeW-1:0];
  assign hi_nib    = run_byte_i[ByteW-1:SizeW];
  assign last_byte = (bytes_left_q == SizeW'(1));

  assign length_merged = put_byte(length_acc_q, byte_index_q, run_byte_i);

  // Final offset byte sits at byte_index_q; bytes above it take its sign bit.
  always_comb begin
    offset_ext = offset_acc_q;
    for (int k = 0; k < FieldBytes; k++) begin
      if (byte_index_q == IdxW'(k)) begin
        offset_ext[k*ByteW +: ByteW] = run_byte_i;
      end else if (byte_index_q < IdxW'(k)) begin
        offset_ext[k*ByteW +: ByteW] = {ByteW{run_byte_i[ByteW-1]}};
      end
    end
  end

  assign off_neg  = run_byte_i[ByteW-1];
  assign sum_wide = {1'b0, prev_eff} + {1'b0, offset_ext};

  always_comb begin
    phase_d        = phase_q;
    bytes_left_d   = bytes_left_q;
    offset_size_d  = offset_size_q;
    byte_index_d   = byte_index_q;
    length_acc_d   = length_acc_q;
    offset_acc_d   = offset_acc_q;
    prev_cluster_d = prev_cluster_q;
    res_new        = 1'b0;
    result_d       = '0;

    if (in_xfer) begin
      phase_d        = phase_eff;
      prev_cluster_d = prev_eff;
      unique case (phase_eff)
        PhHeader: begin
          if (run_byte_i == EndHeader) begin
            phase_d           = PhIgnore;
            res_new           = 1'b1;
            result_d.list_end = 1'b1;
          end else if (lo_nib > MaxFieldBytes || hi_nib > MaxFieldBytes) begin
            phase_d      = PhIgnore;
            res_new      = 1'b1;
            result_d.bad = 1'b1;
          end else begin
            offset_size_d = hi_nib;
            length_acc_d  = '0;
            offset_acc_d  = '0;
            byte_index_d  = '0;
            if (lo_nib != '0) begin
              phase_d      = PhLength;
              bytes_left_d = lo_nib;
            end else begin
              phase_d      = PhOffset;
              bytes_left_d = hi_nib;
            end
          end
        end
        PhLength: begin
          length_acc_d = length_merged;
          bytes_left_d = bytes_left_q - SizeW'(1);
          byte_index_d = byte_index_q + IdxW'(1);
          if (last_byte) begin
            byte_index_d = '0;
            if (offset_size_q == '0) begin
              phase_d                = PhHeader;
              res_new                = 1'b1;
              result_d.cluster_count = length_merged;
              result_d.sparse        = 1'b1;
            end else begin
              phase_d      = PhOffset;
              bytes_left_d = offset_size_q;
            end
          end
        end
        PhOffset: begin
          offset_acc_d = put_byte(offset_acc_q, byte_index_q, run_byte_i);
          bytes_left_d = bytes_left_q - SizeW'(1);
          byte_index_d = byte_index_q + IdxW'(1);
          if (last_byte) begin
            byte_index_d           = '0;
            phase_d                = PhHeader;
            prev_cluster_d         = sum_wide[ClusterW-1:0];
            res_new                = 1'b1;
            result_d.start_cluster = sum_wide[ClusterW-1:0];
            result_d.cluster_count = length_acc_q;
            // Carry out flags overflow for a positive offset, its absence
            // flags underflow for a negative one.
            result_d.bad           = sum_wide[ClusterW] ^ off_neg;
          end
        end
        PhIgnore: begin
          // drop bytes until the next list start
        end
        default: begin
          phase_d = PhIgnore;
        end
      endcase
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_xfer) begin
      out_valid_d = 1'b0;
    end
    if (res_new) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q        <= PhHeader;
      bytes_left_q   <= '0;
      offset_size_q  <= '0;
      byte_index_q   <= '0;
      length_acc_q   <= '0;
      offset_acc_q   <= '0;
      prev_cluster_q <= '0;
      out_valid_q    <= 1'b0;
    end else begin
      phase_q        <= phase_d;
      bytes_left_q   <= bytes_left_d;
      offset_size_q  <= offset_size_d;
      byte_index_q   <= byte_index_d;
      length_acc_q   <= length_acc_d;
      offset_acc_q   <= offset_acc_d;
      prev_cluster_q <= prev_cluster_d;
      out_valid_q    <= out_valid_d;
    end
  end

  // Load the result register only with a new result.
  always_ff @(posedge clk_i) begin
    if (res_new) begin
      result_q <= result_d;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign run_start_cluster_o = result_q.start_cluster;
  assign run_cluster_count_o = result_q.cluster_count;
  assign sparse_run_o        = result_q.sparse;
  assign bad_run_o           = result_q.bad;
  assign list_end_o          = result_q.list_end;

endmodule
